@@ rtl/ccf_pkg.sv @@
// Shared types, constants and fixed-point helpers for the cubic curve core.
// No dependencies; the coefficient unit, evaluation pipeline and top level import it.
`default_nettype none

package ccf_pkg;

  // Wide intermediate format: signed, magnitude clamped to 2^62-1.
  localparam int ACC_W  = 63;
  localparam int MAG_W  = 62;
  localparam int PROD_W = 128;

  localparam logic [MAG_W-1:0] WIDE_MAX = '1;

  localparam logic [2:0] ORD_VALUE  = 3'd0;
  localparam logic [2:0] ORD_FIRST  = 3'd1;
  localparam logic [2:0] ORD_SECOND = 3'd2;
  localparam logic [2:0] ORD_THIRD  = 3'd3;

  localparam logic [2:0] SCALE_3 = 3'd3;
  localparam logic [2:0] SCALE_6 = 3'd6;

  localparam int MUL_ITERS = 64;
  localparam int CNT_W     = 8;

  typedef logic signed [ACC_W-1:0] acc_t;

  typedef enum logic [2:0] {
    REG_START_VALUE  = 3'd0,
    REG_START_RATE   = 3'd1,
    REG_START_ACCEL  = 3'd2,
    REG_END_VALUE    = 3'd3,
    REG_CURVE_LENGTH = 3'd4
  } reg_idx_t;

  typedef enum logic [2:0] {
    CS_IDLE,
    CS_L2,
    CS_P1,
    CS_P2,
    CS_SUM,
    CS_RES,
    CS_CUBE,
    CS_DIV
  } cstate_t;

  // Coefficients and lifted start terms, all in the wide format.
  typedef struct packed {
    acc_t c3_1;
    acc_t c3_3;
    acc_t c3_6;
    acc_t kdd_half;
    acc_t kdd;
    acc_t kdx;
    acc_t kx;
  } coef_t;

  function automatic acc_t with_sign(logic [MAG_W-1:0] m, logic neg);
    acc_t v;
    v = $signed({1'b0, m});
    return neg ? -v : v;
  endfunction

  function automatic logic [MAG_W-1:0] mag_of(acc_t v);
    logic [ACC_W-1:0] n;
    n = v[ACC_W-1] ? -v : v;
    return n[MAG_W-1:0];
  endfunction

  function automatic logic [MAG_W-1:0] clamp_mag(logic [PROD_W-1:0] p);
    return (p > PROD_W'(WIDE_MAX)) ? WIDE_MAX : p[MAG_W-1:0];
  endfunction

  // Shift right with rounding to nearest, ties away from zero, then clamp.
  function automatic logic [MAG_W-1:0] round_shift(logic [PROD_W-1:0] p,
                                                   int unsigned sh);
    logic [PROD_W-1:0] q;
    q = p;
    if (sh > 0) begin
      q = (p + (PROD_W'(1) << (sh - 1))) >> sh;
    end
    return clamp_mag(q);
  endfunction

  function automatic acc_t sadd(acc_t a, acc_t b);
    logic signed [ACC_W:0] s;
    logic signed [ACC_W:0] smax;
    smax = $signed({2'b00, WIDE_MAX});
    s = $signed({a[ACC_W-1], a}) + $signed({b[ACC_W-1], b});
    if (s > smax) begin
      s = smax;
    end else if (s < -smax) begin
      s = -smax;
    end
    return s[ACC_W-1:0];
  endfunction

  // v * 2^n with clamping; v is a sign-extended register value.
  function automatic acc_t lift(logic signed [63:0] v, int unsigned n);
    logic [63:0]       m;
    logic [PROD_W-1:0] p;
    m = v[63] ? -v : v;
    p = {64'd0, m} << n;
    return with_sign(clamp_mag(p), v[63]);
  endfunction

  function automatic acc_t mul_small(acc_t v, logic [2:0] k);
    logic [PROD_W-1:0] p;
    p = PROD_W'(mag_of(v)) * PROD_W'(k);
    return with_sign(clamp_mag(p), v[ACC_W-1]);
  endfunction

endpackage

`default_nettype wire

@@ rtl/ccf_in_if.sv @@
// Input word channel: valid/ready handshake carrying order and point.
// Depends on nothing.
`default_nettype none

interface ccf_in_if #(parameter int WORD_BITS = 32);
  logic                        valid;
  logic                        ready;
  logic [2:0]                  deriv_order;
  logic signed [WORD_BITS-1:0] eval_point;

  modport source (output valid, output deriv_order, output eval_point, input ready);
  modport sink (input valid, input deriv_order, input eval_point, output ready);
endinterface

`default_nettype wire

@@ rtl/ccf_out_if.sv @@
// Result word channel: valid/ready handshake carrying value and flag.
// Depends on nothing.
`default_nettype none

interface ccf_out_if #(parameter int WORD_BITS = 32);
  logic                        valid;
  logic                        ready;
  logic signed [WORD_BITS-1:0] result_value;
  logic                        saturated;

  modport source (output valid, output result_value, output saturated, input ready);
  modport sink (input valid, input result_value, input saturated, output ready);
endinterface

`default_nettype wire

@@ rtl/ccf_coef_unit.sv @@
// Coefficient sequencer: serial multiplier and restoring divider forming c3.
// Depends on ccf_pkg.
`default_nettype none

module ccf_coef_unit #(
  parameter int WORD_BITS = 32,
  parameter int FRAC_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic signed [WORD_BITS-1:0] x0,
  input  logic signed [WORD_BITS-1:0] dx0,
  input  logic signed [WORD_BITS-1:0] ddx0,
  input  logic signed [WORD_BITS-1:0] x1,
  input  logic [WORD_BITS-2:0]        len,
  output logic                        busy,
  output ccf_pkg::coef_t              coef
);
  import ccf_pkg::*;

  localparam int MUL_DONE  = MUL_ITERS + 1;
  localparam int DIV_ITERS = 63 + 3 * FRAC_BITS;
  localparam int DIV_DONE  = DIV_ITERS + 1;

  cstate_t state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r;

  logic [PROD_W-1:0] ma_r, mp_r, d_r, rem_r;
  logic [63:0]       mb_r;
  logic              mneg_r;
  acc_t              l2_r, p1_r, p2_r, sa_r, sb_r, res_r, c3_r;
  logic [62:0]       nsh_r;
  logic [MAG_W-1:0]  q_r;
  logic              qsat_r;

  logic [63:0]       len_eff, mag_dx, mag_ddx;
  logic signed [63:0] ext_dx, ext_ddx;
  logic [63:0]       op_a, op_b;
  logic              op_neg;
  int unsigned       op_sh;
  acc_t              mul_res;
  logic              mul_state;

  logic [PROD_W-1:0] r2;
  logic              one;
  logic [MAG_W:0]    qn;
  logic [MAG_W:0]    qr;
  logic [MAG_W-1:0]  q_final;

  always_comb begin
    len_eff = (len == '0) ? 64'd1 : 64'(len);
    ext_dx  = 64'(dx0);
    ext_ddx = 64'(ddx0);
    mag_dx  = ext_dx[63] ? -ext_dx : ext_dx;
    mag_ddx = ext_ddx[63] ? -ext_ddx : ext_ddx;
  end

  // Operand selection for the shared multiplier.
  always_comb begin
    op_a   = len_eff;
    op_b   = len_eff;
    op_neg = 1'b0;
    op_sh  = FRAC_BITS;
    case (state_r)
      CS_L2: begin
        op_a = len_eff;
      end
      CS_P1: begin
        op_a   = mag_dx;
        op_neg = dx0[WORD_BITS-1];
      end
      CS_P2: begin
        op_a   = mag_ddx;
        op_b   = 64'(mag_of(l2_r));
        op_neg = ddx0[WORD_BITS-1];
        op_sh  = FRAC_BITS + 1;
      end
      CS_CUBE: begin
        op_a  = 64'(mag_of(l2_r));
        op_sh = 0;
      end
      default: begin
        op_a = len_eff;
      end
    endcase
    mul_res   = with_sign(round_shift(mp_r, op_sh), mneg_r);
    mul_state = (state_r == CS_L2) || (state_r == CS_P1) ||
                (state_r == CS_P2) || (state_r == CS_CUBE);
  end

  // One divider step.
  always_comb begin
    r2 = {rem_r[PROD_W-2:0], nsh_r[62]};
    one = (r2 >= d_r);
    qn = {q_r, one};
    qr = {1'b0, q_r} + (MAG_W+1)'(1);
    if (!qsat_r && ({rem_r[PROD_W-2:0], 1'b0} >= d_r)) begin
      q_final = (qr > (MAG_W+1)'(WIDE_MAX)) ? WIDE_MAX : qr[MAG_W-1:0];
    end else begin
      q_final = q_r;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      CS_IDLE: state_nxt = CS_IDLE;
      CS_L2:   if (cnt_r == CNT_W'(MUL_DONE)) state_nxt = CS_P1;
      CS_P1:   if (cnt_r == CNT_W'(MUL_DONE)) state_nxt = CS_P2;
      CS_P2:   if (cnt_r == CNT_W'(MUL_DONE)) state_nxt = CS_SUM;
      CS_SUM:  state_nxt = CS_RES;
      CS_RES:  state_nxt = CS_CUBE;
      CS_CUBE: if (cnt_r == CNT_W'(MUL_DONE)) state_nxt = CS_DIV;
      CS_DIV: begin
        if ((cnt_r == '0 && d_r == '0) || cnt_r == CNT_W'(DIV_DONE)) begin
          state_nxt = CS_IDLE;
        end
      end
      default: state_nxt = CS_IDLE;
    endcase
    if (start) begin
      state_nxt = CS_L2;
    end
  end

  always_comb begin
    busy = (state_r != CS_IDLE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= CS_IDLE;
      cnt_r   <= '0;
      c3_r    <= '0;
    end else begin
      state_r <= state_nxt;
      if (start || state_nxt != state_r || state_r == CS_IDLE) begin
        cnt_r <= '0;
      end else begin
        cnt_r <= cnt_r + CNT_W'(1);
      end
      if (state_r == CS_DIV && !start) begin
        if (cnt_r == '0 && d_r == '0) begin
          if (res_r > 0) begin
            c3_r <= with_sign(WIDE_MAX, 1'b0);
          end else if (res_r < 0) begin
            c3_r <= with_sign(WIDE_MAX, 1'b1);
          end else begin
            c3_r <= '0;
          end
        end else if (cnt_r == CNT_W'(DIV_DONE)) begin
          c3_r <= with_sign(q_final, res_r[ACC_W-1]);
        end
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (mul_state) begin
      if (cnt_r == '0) begin
        ma_r   <= PROD_W'(op_a);
        mb_r   <= op_b;
        mneg_r <= op_neg;
        mp_r   <= '0;
      end else if (cnt_r <= CNT_W'(MUL_ITERS)) begin
        if (mb_r[0]) begin
          mp_r <= mp_r + ma_r;
        end
        ma_r <= ma_r << 1;
        mb_r <= mb_r >> 1;
      end else begin
        case (state_r)
          CS_L2:   l2_r <= mul_res;
          CS_P1:   p1_r <= mul_res;
          CS_P2:   p2_r <= mul_res;
          default: d_r  <= mp_r;
        endcase
      end
    end
    if (state_r == CS_SUM) begin
      sa_r <= sadd(acc_t'(x1), -acc_t'(x0));
      sb_r <= sadd(p1_r, p2_r);
    end
    if (state_r == CS_RES) begin
      res_r <= sadd(sa_r, -sb_r);
    end
    if (state_r == CS_DIV) begin
      if (cnt_r == '0) begin
        rem_r  <= '0;
        nsh_r  <= {1'b0, mag_of(res_r)};
        q_r    <= '0;
        qsat_r <= 1'b0;
      end else if (cnt_r <= CNT_W'(DIV_ITERS)) begin
        nsh_r <= nsh_r << 1;
        rem_r <= one ? (r2 - d_r) : r2;
        if (!qsat_r) begin
          if (qn > (MAG_W+1)'(WIDE_MAX)) begin
            q_r    <= WIDE_MAX;
            qsat_r <= 1'b1;
          end else begin
            q_r <= qn[MAG_W-1:0];
          end
        end
      end
    end
  end

  always_comb begin
    coef.c3_1     = c3_r;
    coef.c3_3     = mul_small(c3_r, SCALE_3);
    coef.c3_6     = mul_small(c3_r, SCALE_6);
    coef.kdd_half = lift(64'(ddx0), FRAC_BITS - 1);
    coef.kdd      = lift(64'(ddx0), FRAC_BITS);
    coef.kdx      = lift(64'(dx0), FRAC_BITS);
    coef.kx       = lift(64'(x0), FRAC_BITS);
  end

endmodule

`default_nettype wire

@@ rtl/ccf_eval_pipe.sv @@
// Horner evaluation pipeline: entry stage, three steps of three stages, output.
// Depends on ccf_pkg.
`default_nettype none

module ccf_eval_pipe #(
  parameter int WORD_BITS = 32,
  parameter int FRAC_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  ccf_pkg::coef_t              coef,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [2:0]                  in_order,
  input  logic signed [WORD_BITS-1:0] in_t,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic signed [WORD_BITS-1:0] out_value,
  output logic                        out_sat
);
  import ccf_pkg::*;

  localparam int NSTEP  = 3;
  localparam int NST    = 2 + 3 * NSTEP;
  localparam int OUT_IX = NST - 1;
  localparam int PW     = 63 + WORD_BITS;

  logic [NST-1:0] v_r, rdy;

  always_comb begin
    rdy[OUT_IX] = !v_r[OUT_IX] || out_ready;
    for (int i = OUT_IX - 1; i >= 0; i--) begin
      rdy[i] = !v_r[i] || rdy[i+1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (rdy[0]) begin
        v_r[0] <= in_valid;
      end
      for (int i = 1; i < NST; i++) begin
        if (rdy[i]) begin
          v_r[i] <= v_r[i-1];
        end
      end
    end
  end

  assign in_ready = rdy[0];

  // Entry stage picks the leading coefficient for the order.
  acc_t                  s0_acc_r;
  logic [2:0]            s0_ord_r;
  logic signed [WORD_BITS-1:0] s0_t_r;

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      s0_ord_r <= in_order;
      s0_t_r   <= in_t;
      case (in_order)
        ORD_VALUE:  s0_acc_r <= coef.c3_1;
        ORD_FIRST:  s0_acc_r <= coef.c3_3;
        ORD_SECOND: s0_acc_r <= coef.c3_6;
        ORD_THIRD:  s0_acc_r <= coef.c3_6;
        default:    s0_acc_r <= '0;
      endcase
    end
  end

  acc_t                        st_acc [NSTEP];
  logic [2:0]                  st_ord [NSTEP];
  logic signed [WORD_BITS-1:0] st_t   [NSTEP];
  acc_t                        c_acc_r [NSTEP];
  logic [2:0]                  c_ord_r [NSTEP];
  logic signed [WORD_BITS-1:0] c_t_r   [NSTEP];

  for (genvar s = 0; s < NSTEP; s++) begin : g_step
    localparam int IA = 1 + 3 * s;
    localparam int IB = 2 + 3 * s;
    localparam int IC = 3 + 3 * s;

    if (s == 0) begin : g_first
      assign st_acc[s] = s0_acc_r;
      assign st_ord[s] = s0_ord_r;
      assign st_t[s]   = s0_t_r;
    end else begin : g_next
      assign st_acc[s] = c_acc_r[s-1];
      assign st_ord[s] = c_ord_r[s-1];
      assign st_t[s]   = c_t_r[s-1];
    end

    // Stage A: partial products of |acc| halves by |t|.
    logic [MAG_W-1:0]     mag_a;
    logic [WORD_BITS:0]   tn;
    logic [WORD_BITS-1:0] mag_t;
    logic [31+WORD_BITS:0] pl_r;
    logic [29+WORD_BITS:0] ph_r;
    logic                  neg_r;
    acc_t                  a_acc_r;
    logic [2:0]            a_ord_r;
    logic signed [WORD_BITS-1:0] a_t_r;

    always_comb begin
      mag_a = mag_of(st_acc[s]);
      tn    = st_t[s][WORD_BITS-1] ? -{st_t[s][WORD_BITS-1], st_t[s]}
                                   : {st_t[s][WORD_BITS-1], st_t[s]};
      mag_t = tn[WORD_BITS-1:0];
    end

    always_ff @(posedge clk) begin
      if (rdy[IA]) begin
        pl_r    <= (WORD_BITS+32)'(mag_a[31:0]) * (WORD_BITS+32)'(mag_t);
        ph_r    <= (WORD_BITS+30)'(mag_a[MAG_W-1:32]) * (WORD_BITS+30)'(mag_t);
        neg_r   <= st_acc[s][ACC_W-1] ^ st_t[s][WORD_BITS-1];
        a_acc_r <= st_acc[s];
        a_ord_r <= st_ord[s];
        a_t_r   <= st_t[s];
      end
    end

    // Stage B: combine, round, shift by the fraction width, clamp.
    logic [PW-1:0]    psum, pshift;
    logic [MAG_W-1:0] pmag;
    acc_t             prod_r, b_acc_r;
    logic [2:0]       b_ord_r;
    logic signed [WORD_BITS-1:0] b_t_r;

    always_comb begin
      psum   = PW'(pl_r) + (PW'(ph_r) << 32) + (PW'(1) << (FRAC_BITS - 1));
      pshift = psum >> FRAC_BITS;
      pmag   = (pshift > PW'(WIDE_MAX)) ? WIDE_MAX : pshift[MAG_W-1:0];
    end

    always_ff @(posedge clk) begin
      if (rdy[IB]) begin
        prod_r  <= with_sign(pmag, neg_r);
        b_acc_r <= a_acc_r;
        b_ord_r <= a_ord_r;
        b_t_r   <= a_t_r;
      end
    end

    // Stage C: add the next coefficient, or pass through for higher derivative orders.
    logic act;
    acc_t kc;

    if (s == 0) begin : g_c0
      always_comb begin
        act = b_ord_r inside {ORD_VALUE, ORD_FIRST, ORD_SECOND};
        kc  = (b_ord_r == ORD_VALUE) ? coef.kdd_half : coef.kdd;
      end
    end else if (s == 1) begin : g_c1
      always_comb begin
        act = b_ord_r inside {ORD_VALUE, ORD_FIRST};
        kc  = coef.kdx;
      end
    end else begin : g_c2
      always_comb begin
        act = (b_ord_r == ORD_VALUE);
        kc  = coef.kx;
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[IC]) begin
        c_acc_r[s] <= act ? sadd(prod_r, kc) : b_acc_r;
        c_ord_r[s] <= b_ord_r;
        c_t_r[s]   <= b_t_r;
      end
    end
  end

  // Output stage: round to the word format and saturate.
  acc_t            fin;
  logic            fneg;
  logic [62:0]     fm, fs, pos_max, neg_lim, fneg_v;
  logic signed [WORD_BITS-1:0] val;
  logic            sat;
  logic signed [WORD_BITS-1:0] out_value_r;
  logic            out_sat_r;

  always_comb begin
    fin     = c_acc_r[NSTEP-1];
    fneg    = fin[ACC_W-1];
    fm      = {1'b0, mag_of(fin)} + (63'(1) << (FRAC_BITS - 1));
    fs      = fm >> FRAC_BITS;
    pos_max = (63'(1) << (WORD_BITS - 1)) - 63'(1);
    neg_lim = 63'(1) << (WORD_BITS - 1);
    fneg_v  = fneg ? -fs : fs;
    sat     = 1'b0;
    if (!fneg && fs > pos_max) begin
      val = {1'b0, {(WORD_BITS-1){1'b1}}};
      sat = 1'b1;
    end else if (fneg && fs > neg_lim) begin
      val = {1'b1, {(WORD_BITS-1){1'b0}}};
      sat = 1'b1;
    end else begin
      val = fneg_v[WORD_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[OUT_IX]) begin
      out_value_r <= val;
      out_sat_r   <= sat;
    end
  end

  assign out_valid = v_r[OUT_IX];
  assign out_value = out_value_r;
  assign out_sat   = out_sat_r;

endmodule

`default_nettype wire

@@ rtl/cubic_curve_fit_and_evaluate_core.sv @@
// Top level of the cubic curve core: register port, coefficient unit, pipeline.
// Depends on ccf_pkg, ccf_in_if, ccf_out_if, ccf_coef_unit and ccf_eval_pipe.
`default_nettype none

// The core fits a cubic to a start value, rate and acceleration and an end
// value over a curve length, then evaluates the cubic or one of its first
// three derivatives at one point per input word, saturating to the word
// format. The evaluation pipeline takes one word per cycle when not stalled
// and has an entry stage, three Horner steps of three stages each (partial
// products, round and clamp, coefficient add), and an output stage. Stalls
// on the result side hold words in place and bubbles close up, so the core
// keeps accepting while a result waits until the pipeline is full. After
// each register write the coefficient unit recomputes c3 with a serial
// multiplier (four products) and a one-bit-per-cycle divider; input ready
// stays low until it finishes. Further writes during that time restart it.
module cubic_curve_fit_and_evaluate_core #(
  parameter int WORD_BITS = 32,
  parameter int FRAC_BITS = 16,
  localparam int CFG_ASH = (WORD_BITS > 32) ? 3 : 2,
  localparam int CFG_AW  = CFG_ASH + 3,
  localparam int CFG_DW  = (WORD_BITS > 32) ? 64 : 32
) (
  input  logic              clk,
  input  logic              rst_n,
  ccf_in_if.sink            in_port,
  ccf_out_if.source         out_port,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [CFG_DW-1:0] cfg_pwdata,
  output logic [CFG_DW-1:0] cfg_prdata,
  output logic              cfg_pready
);
  import ccf_pkg::*;

  logic signed [WORD_BITS-1:0] x0_r, dx0_r, ddx0_r, x1_r;
  logic [WORD_BITS-2:0]        len_r;
  logic                        cfg_wr;
  reg_idx_t                    cfg_idx;
  logic                        cu_busy;
  coef_t                       coef;
  logic                        pipe_ready;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_idx    = reg_idx_t'(cfg_paddr[CFG_AW-1:CFG_ASH]);

  // Register writes; indexes past the curve length are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x0_r   <= '0;
      dx0_r  <= '0;
      ddx0_r <= '0;
      x1_r   <= '0;
      len_r  <= (WORD_BITS-1)'(1) << FRAC_BITS;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_START_VALUE:  x0_r   <= cfg_pwdata[WORD_BITS-1:0];
        REG_START_RATE:   dx0_r  <= cfg_pwdata[WORD_BITS-1:0];
        REG_START_ACCEL:  ddx0_r <= cfg_pwdata[WORD_BITS-1:0];
        REG_END_VALUE:    x1_r   <= cfg_pwdata[WORD_BITS-1:0];
        REG_CURVE_LENGTH: len_r  <= cfg_pwdata[WORD_BITS-2:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_START_VALUE:  cfg_prdata = CFG_DW'($unsigned(x0_r));
      REG_START_RATE:   cfg_prdata = CFG_DW'($unsigned(dx0_r));
      REG_START_ACCEL:  cfg_prdata = CFG_DW'($unsigned(ddx0_r));
      REG_END_VALUE:    cfg_prdata = CFG_DW'($unsigned(x1_r));
      REG_CURVE_LENGTH: cfg_prdata = CFG_DW'(len_r);
      default:          cfg_prdata = '0;
    endcase
  end

  // Any write restarts the coefficient computation.
  ccf_coef_unit #(
    .WORD_BITS(WORD_BITS),
    .FRAC_BITS(FRAC_BITS)
  ) u_coef (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cfg_wr),
    .x0    (x0_r),
    .dx0   (dx0_r),
    .ddx0  (ddx0_r),
    .x1    (x1_r),
    .len   (len_r),
    .busy  (cu_busy),
    .coef  (coef)
  );

  // Input words are held off while the coefficients are being refreshed.
  ccf_eval_pipe #(
    .WORD_BITS(WORD_BITS),
    .FRAC_BITS(FRAC_BITS)
  ) u_pipe (
    .clk       (clk),
    .rst_n     (rst_n),
    .coef      (coef),
    .in_valid  (in_port.valid && !cu_busy),
    .in_ready  (pipe_ready),
    .in_order  (in_port.deriv_order),
    .in_t      (in_port.eval_point),
    .out_valid (out_port.valid),
    .out_ready (out_port.ready),
    .out_value (out_port.result_value),
    .out_sat   (out_port.saturated)
  );

  assign in_port.ready = pipe_ready && !cu_busy;

  // A register write always leaves the coefficient unit running.
  a_write_starts: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_wr |=> cu_busy)
    else $error("coefficient unit idle after a register write");

  // No input word slips in right behind a register write.
  a_no_accept_after_write: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_wr |=> !(in_port.valid && in_port.ready))
    else $error("input word accepted while coefficients are stale");

  // A flagged result sits at one of the range limits.
  a_sat_at_limit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_port.valid && out_port.saturated) |->
      (out_port.result_value == {1'b0, {(WORD_BITS-1){1'b1}}}) ||
      (out_port.result_value == {1'b1, {(WORD_BITS-1){1'b0}}}))
    else $error("saturation flag without a limit value");

endmodule

`default_nettype wire
